FILE: design/emtm_pkg.sv
// ============================================================================
// emtm_pkg
// Shared types, codes and constants of the model matrix block.
// ============================================================================
package emtm_pkg;

    // Default fixed-point and angle formats.
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ANGLE_BITS_DEF = 16;

    // Operation codes carried in the input tuser field.
    localparam logic [1:0] OP_TRANSLATE = 2'd0;
    localparam logic [1:0] OP_ROTATE    = 2'd1;
    localparam logic [1:0] OP_SCALE     = 2'd2;
    localparam logic [1:0] OP_READ      = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TRANSLATE_GAIN = 2'd0;
    localparam logic [1:0] CFG_ROTATE_GAIN    = 2'd1;
    localparam logic [1:0] CFG_SCALE_GAIN     = 2'd2;

    localparam logic [15:0] GAIN_RESET = 16'd256;

    // Sine polynomial coefficients in Q30.
    localparam logic [31:0] SIN_A = 32'd1686629713;
    localparam logic [31:0] SIN_C = 32'd76016977;
    localparam logic [31:0] SIN_B = 32'd688904866;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    // Start request from the stream side to the core.
    typedef struct packed {
        logic             start;
        logic [1:0]       op;
        logic [3:0][31:0] delta;
    } emtm_cmd_t;

    // Gain registers, unsigned Q8.8.
    typedef struct packed {
        logic [15:0] translate;
        logic [15:0] rotate;
        logic [15:0] scale;
    } emtm_gain_t;

    // Finished matrix: scaled rotation in column-major order and the offsets.
    typedef struct packed {
        logic [8:0][31:0] elem;
        logic [31:0]      pos_x;
        logic [31:0]      pos_y;
        logic [31:0]      pos_z;
    } emtm_mat_t;

    // Saturate a wide signed value to 32 bits.
    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] r;
        if (v > SAT_MAX)
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < SAT_MIN)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: design/emtm_mul.sv
// ============================================================================
// emtm_mul
// Shared signed 33 x 33 multiplier with a registered product.
// ============================================================================
module emtm_mul
(
    input  logic                clk,
    input  logic signed [32:0]  a,
    input  logic signed [32:0]  b,
    output logic signed [65:0]  prod
);

    logic signed [65:0] prod_reg;

    // The product is registered before any use.
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

FILE: design/emtm_core.sv
// ============================================================================
// emtm_core
// Pose registers and the sequencer that drives the shared multiplier through
// the pose update, six sine evaluations, the rotation product and the scaling.
// ============================================================================
module emtm_core #(
    parameter int FRAC_BITS  = emtm_pkg::FRAC_BITS_DEF,
    parameter int ANGLE_BITS = emtm_pkg::ANGLE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  emtm_pkg::emtm_cmd_t  cmd,
    input  emtm_pkg::emtm_gain_t gain,
    output emtm_pkg::emtm_mat_t  mat,
    output logic                 done
);
    import emtm_pkg::*;

    localparam int TRIG_W  = FRAC_BITS + 2;
    localparam int R_W     = FRAC_BITS + 3;
    localparam int X_SHIFT = 32 - ANGLE_BITS;

    localparam logic signed [32:0] ONE_Q    = 33'sd1 <<< FRAC_BITS;
    localparam logic signed [65:0] HALF_Q   = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] Y_HALF   = 66'sd1 <<< (29 - FRAC_BITS);
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [31:0] POS_Z_RESET = 32'(-(64'sd1 <<< FRAC_BITS));
    localparam logic [31:0] SCALE_RESET = 32'(64'sd2 <<< FRAC_BITS);

    // Sequencer phases.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_GAIN  = 3'd1;
    localparam logic [2:0] PH_SINE  = 3'd2;
    localparam logic [2:0] PH_ROT   = 3'd3;
    localparam logic [2:0] PH_SCALE = 3'd4;

    logic [2:0] phase_reg, phase_next;
    logic [4:0] idx_reg, idx_next, idx_last;
    logic       wb_reg, wb_next;
    logic       done_reg, done_next;

    logic [1:0]       op_reg;
    logic [3:0][31:0] delta_reg;

    logic signed [31:0] pos_x_reg, pos_y_reg, pos_z_reg, scale_reg;
    logic [ANGLE_BITS-1:0] angle_x_reg, angle_y_reg, angle_z_reg;

    logic [30:0]        x_reg, x2_reg;
    logic [1:0]         quad_reg;
    logic signed [31:0] t_reg;

    logic signed [TRIG_W-1:0] sx_reg, cx_reg, sy_reg, cy_reg, sz_reg, cz_reg;
    logic signed [R_W-1:0]    p_reg, q_reg, acc_reg;
    logic [8:0][R_W-1:0]      rot_reg;
    logic [8:0][31:0]         elem_reg;

    logic signed [32:0] a_op, b_op;
    logic signed [65:0] prod;

    logic [2:0] sn;
    logic [1:0] sub;
    logic [ANGLE_BITS-1:0] ang_sel, ang_eff;
    logic [1:0]  quad_comb;
    logic [30:0] x_raw, x_comb;
    logic [15:0] gain_sel;

    logic signed [65:0] applied, sh30, r_round, q_full, pos_sel, pos_sum;
    logic signed [TRIG_W-1:0] trig_new;
    logic signed [R_W-1:0]    qv;

    assign sn  = idx_reg[4:2];
    assign sub = idx_reg[1:0];

    // Fraction of the current sine argument, mirrored in odd quadrants.
    always_comb
    begin
        case (sn[2:1])
            2'd0:    ang_sel = angle_x_reg;
            2'd1:    ang_sel = angle_y_reg;
            default: ang_sel = angle_z_reg;
        endcase
        ang_eff   = sn[0] ? ang_sel + QUARTER : ang_sel;
        quad_comb = ang_eff[ANGLE_BITS-1:ANGLE_BITS-2];
        x_raw     = 31'(ang_eff[ANGLE_BITS-3:0]) << X_SHIFT;
        x_comb    = quad_comb[0] ? (31'd1 << 30) - x_raw : x_raw;
    end

    // Gain for the current delta.
    always_comb
    begin
        if (idx_reg == 5'd3)
        begin
            gain_sel = gain.scale;
        end
        else if (op_reg == OP_ROTATE)
        begin
            gain_sel = gain.rotate;
        end
        else
        begin
            gain_sel = gain.translate;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        a_op = '0;
        b_op = '0;
        case (phase_reg)
            PH_GAIN:
            begin
                a_op = 33'($signed(delta_reg[idx_reg[1:0]]));
                b_op = 33'(gain_sel);
            end
            PH_SINE:
            begin
                case (sub)
                    2'd0:
                    begin
                        a_op = 33'(x_comb);
                        b_op = 33'(x_comb);
                    end
                    2'd1:
                    begin
                        a_op = 33'(x2_reg);
                        b_op = 33'(SIN_C);
                    end
                    2'd2:
                    begin
                        a_op = 33'(x2_reg);
                        b_op = 33'(t_reg);
                    end
                    default:
                    begin
                        a_op = 33'(x_reg);
                        b_op = 33'(t_reg);
                    end
                endcase
            end
            PH_ROT:
            begin
                case (idx_reg)
                    5'd0:    begin a_op = 33'(cz_reg); b_op = 33'(sy_reg); end
                    5'd1:    begin a_op = 33'(sz_reg); b_op = 33'(sy_reg); end
                    5'd2:    begin a_op = 33'(cz_reg); b_op = 33'(cy_reg); end
                    5'd3:    begin a_op = 33'(sz_reg); b_op = 33'(cy_reg); end
                    5'd4:    begin a_op = 33'(sy_reg); b_op = ONE_Q;        end
                    5'd5:    begin a_op = 33'(sz_reg); b_op = 33'(cx_reg); end
                    5'd6:    begin a_op = 33'(p_reg);  b_op = 33'(sx_reg); end
                    5'd7:    begin a_op = 33'(cz_reg); b_op = 33'(cx_reg); end
                    5'd8:    begin a_op = 33'(q_reg);  b_op = 33'(sx_reg); end
                    5'd9:    begin a_op = 33'(cy_reg); b_op = 33'(sx_reg); end
                    5'd10:   begin a_op = 33'(sz_reg); b_op = 33'(sx_reg); end
                    5'd11:   begin a_op = 33'(p_reg);  b_op = 33'(cx_reg); end
                    5'd12:   begin a_op = 33'(cz_reg); b_op = 33'(sx_reg); end
                    5'd13:   begin a_op = 33'(q_reg);  b_op = 33'(cx_reg); end
                    default: begin a_op = 33'(cy_reg); b_op = 33'(cx_reg); end
                endcase
            end
            PH_SCALE:
            begin
                a_op = 33'(scale_reg);
                b_op = 33'($signed(rot_reg[idx_reg[3:0]]));
            end
            default:
            begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    emtm_mul u_mul
    (
        .clk  (clk),
        .a    (a_op),
        .b    (b_op),
        .prod (prod)
    );

    // Post-processing of the registered product.
    always_comb
    begin
        applied = prod >>> 8;
        sh30    = prod >>> 30;
        r_round = (sh30 + Y_HALF) >>> (30 - FRAC_BITS);
        trig_new = quad_reg[1] ? TRIG_W'(-r_round) : TRIG_W'(r_round);
        q_full  = (prod + HALF_Q) >>> FRAC_BITS;
        qv      = R_W'(q_full);
        case (idx_reg[1:0])
            2'd0:    pos_sel = 66'(pos_x_reg);
            2'd1:    pos_sel = 66'(pos_y_reg);
            default: pos_sel = 66'(pos_z_reg);
        endcase
        pos_sum = pos_sel + applied;
    end

    // Last step of each phase.
    always_comb
    begin
        case (phase_reg)
            PH_GAIN:  idx_last = 5'd3;
            PH_SINE:  idx_last = 5'd23;
            PH_ROT:   idx_last = 5'd14;
            PH_SCALE: idx_last = 5'd8;
            default:  idx_last = 5'd0;
        endcase
    end

    // Sequencer: each step issues a multiply, then writes the registered product back.
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        wb_next    = wb_reg;
        done_next  = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            if (cmd.start)
            begin
                phase_next = PH_GAIN;
                idx_next   = '0;
                wb_next    = 1'b0;
            end
        end
        else if (!wb_reg)
        begin
            wb_next = 1'b1;
        end
        else
        begin
            wb_next = 1'b0;
            if (idx_reg == idx_last)
            begin
                idx_next = '0;
                case (phase_reg)
                    PH_GAIN: phase_next = PH_SINE;
                    PH_SINE: phase_next = PH_ROT;
                    PH_ROT:  phase_next = PH_SCALE;
                    default:
                    begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                endcase
            end
            else
            begin
                idx_next = idx_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            idx_reg   <= '0;
            wb_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            wb_reg    <= wb_next;
            done_reg  <= done_next;
        end
    end

    // Pose state: offsets and scale saturate, angles wrap.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            pos_z_reg   <= POS_Z_RESET;
            angle_x_reg <= '0;
            angle_y_reg <= '0;
            angle_z_reg <= '0;
            scale_reg   <= SCALE_RESET;
        end
        else if (phase_reg == PH_GAIN && wb_reg)
        begin
            if (idx_reg == 5'd3)
            begin
                if (op_reg == OP_SCALE)
                begin
                    scale_reg <= sat32(66'(scale_reg) + applied);
                end
            end
            else if (op_reg == OP_TRANSLATE)
            begin
                case (idx_reg[1:0])
                    2'd0:    pos_x_reg <= sat32(pos_sum);
                    2'd1:    pos_y_reg <= sat32(pos_sum);
                    default: pos_z_reg <= sat32(pos_sum);
                endcase
            end
            else if (op_reg == OP_ROTATE)
            begin
                case (idx_reg[1:0])
                    2'd0:    angle_x_reg <= angle_x_reg + applied[ANGLE_BITS-1:0];
                    2'd1:    angle_y_reg <= angle_y_reg + applied[ANGLE_BITS-1:0];
                    default: angle_z_reg <= angle_z_reg + applied[ANGLE_BITS-1:0];
                endcase
            end
        end
    end

    // Request capture and the working registers of the datapath.
    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && cmd.start)
        begin
            op_reg    <= cmd.op;
            delta_reg <= cmd.delta;
        end
        if (wb_reg && phase_reg == PH_SINE)
        begin
            case (sub)
                2'd0:
                begin
                    x_reg    <= x_comb;
                    quad_reg <= quad_comb;
                    x2_reg   <= sh30[30:0];
                end
                2'd1: t_reg <= 32'(66'(SIN_B) - sh30);
                2'd2: t_reg <= 32'(66'(SIN_A) - sh30);
                default:
                begin
                    case (sn)
                        3'd0:    sx_reg <= trig_new;
                        3'd1:    cx_reg <= trig_new;
                        3'd2:    sy_reg <= trig_new;
                        3'd3:    cy_reg <= trig_new;
                        3'd4:    sz_reg <= trig_new;
                        default: cz_reg <= trig_new;
                    endcase
                end
            endcase
        end
        if (wb_reg && phase_reg == PH_ROT)
        begin
            case (idx_reg)
                5'd0:  p_reg <= qv;
                5'd1:  q_reg <= qv;
                5'd2:  rot_reg[0] <= qv;
                5'd3:  rot_reg[1] <= R_W'(-qv);
                5'd4:  rot_reg[2] <= qv;
                5'd6:  rot_reg[3] <= R_W'(acc_reg + qv);
                5'd8:  rot_reg[4] <= R_W'(acc_reg - qv);
                5'd9:  rot_reg[5] <= R_W'(-qv);
                5'd11: rot_reg[6] <= R_W'(acc_reg - qv);
                5'd13: rot_reg[7] <= R_W'(acc_reg + qv);
                5'd14: rot_reg[8] <= qv;
                default: acc_reg <= qv;
            endcase
        end
        if (wb_reg && phase_reg == PH_SCALE)
        begin
            elem_reg[idx_reg[3:0]] <= sat32(q_full);
        end
    end

    assign mat.elem  = elem_reg;
    assign mat.pos_x = pos_x_reg;
    assign mat.pos_y = pos_y_reg;
    assign mat.pos_z = pos_z_reg;
    assign done      = done_reg;

    // The step counter never passes the last step of its phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_IDLE |-> idx_reg <= idx_last)
        else $error("emtm_core: step index beyond phase end");

    // Completion follows the last write-back of the scaling phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(phase_reg) == PH_SCALE && $past(wb_reg))
        else $error("emtm_core: completion without scaling phase");

    // A new request is only taken while the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE && cmd.start) |=> phase_reg == PH_GAIN && !wb_reg)
        else $error("emtm_core: request not started");

endmodule

FILE: design/euler_trs_model_matrix.sv
// Four columns per request, one column per cycle while the output is taken.
// A new request is accepted only once the last column of the previous one is taken.
// The core runs 52 steps on the single shared multiplier, each a multiply followed by
// a write-back of the registered product; a stalled column holds the output.
// Reset: gains return to 1.0, the pose to offset (0, 0, -1), zero angles, scale 2.
// ============================================================================
// euler_trs_model_matrix
// Object pose keeper that emits the model matrix T*S*Rz*Ry*Rx column by column.
// ============================================================================
module euler_trs_model_matrix #(
    parameter int FRAC_BITS  = emtm_pkg::FRAC_BITS_DEF,
    parameter int ANGLE_BITS = emtm_pkg::ANGLE_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // delta_x, delta_y, delta_z, delta_factor
    input  logic [1:0]   s_tuser,   // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // elem_row0, elem_row1, elem_row2, elem_row3
    output logic [1:0]   m_tuser,   // column_index
    output logic         m_tlast    // last_column
);
    import emtm_pkg::*;

    localparam logic [31:0] ONE_32 = 32'(64'sd1 <<< FRAC_BITS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]   state_reg, state_next;
    logic [1:0]   col_reg, col_next;
    logic         valid_reg, valid_next;
    logic [127:0] data_reg;
    logic [1:0]   col_sel;
    logic [127:0] col_data;
    logic         load;

    emtm_gain_t gain_reg;
    emtm_cmd_t  cmd;
    emtm_mat_t  mat;
    logic       done;

    // Gain registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg.translate <= GAIN_RESET;
            gain_reg.rotate    <= GAIN_RESET;
            gain_reg.scale     <= GAIN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TRANSLATE_GAIN: gain_reg.translate <= cfg_data;
                CFG_ROTATE_GAIN:    gain_reg.rotate    <= cfg_data;
                CFG_SCALE_GAIN:     gain_reg.scale     <= cfg_data;
                default:            gain_reg.scale     <= gain_reg.scale;
            endcase
        end
    end

    assign s_tready    = (state_reg == ST_IDLE);
    assign cmd.start   = s_tvalid && s_tready;
    assign cmd.op      = s_tuser;
    assign cmd.delta   = s_tdata;

    emtm_core #(
        .FRAC_BITS  (FRAC_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .gain  (gain_reg),
        .mat   (mat),
        .done  (done)
    );

    // Column builder: rows 0 to 2 of the scaled rotation, or the offsets.
    always_comb
    begin
        col_sel = (state_reg == ST_OUT) ? col_reg + 2'd1 : 2'd0;
        case (col_sel)
            2'd0:    col_data = {32'd0, mat.elem[2], mat.elem[1], mat.elem[0]};
            2'd1:    col_data = {32'd0, mat.elem[5], mat.elem[4], mat.elem[3]};
            2'd2:    col_data = {32'd0, mat.elem[8], mat.elem[7], mat.elem[6]};
            default: col_data = {ONE_32, mat.pos_z, mat.pos_y, mat.pos_x};
        endcase
    end

    // Output sequencing over the four columns.
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        valid_next = valid_reg;
        load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (done)
                begin
                    state_next = ST_OUT;
                    col_next   = 2'd0;
                    valid_next = 1'b1;
                    load       = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    if (col_reg == 2'd3)
                    begin
                        state_next = ST_IDLE;
                        valid_next = 1'b0;
                    end
                    else
                    begin
                        col_next = col_reg + 2'd1;
                        load     = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= col_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = col_reg;
    assign m_tlast  = (col_reg == 2'd3);

    // Input and output sides are never open at the same time.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("euler_trs_model_matrix: ready while output pending");

    // The core only finishes while a request is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == ST_BUSY)
        else $error("euler_trs_model_matrix: completion while not busy");

    // The last column taken frees the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("euler_trs_model_matrix: not ready after last column");

endmodule

FILE: tb/euler_trs_model_matrix_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// euler_trs_model_matrix_tb
// This bench drives pose update requests into the model matrix block and
// checks each matrix column that comes back. Expected columns are computed
// by a local pose model. A short table of directed requests runs first,
// followed by random requests under several gain settings.
// ============================================================================
module euler_trs_model_matrix_tb;
    import emtm_pkg::*;

    // Register index past the end of the list; writes to it are dropped.
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        logic [1:0]   col;
        logic [127:0] data;
        logic         last;
    } column_t;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] dx;
        logic [31:0] dy;
        logic [31:0] dz;
        logic [31:0] df;
        logic        check_fixed;
        logic [31:0] fixed_row0;
    } step_row_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_write;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    // Local copy of the pose and gains.
    longint    gain_t, gain_r, gain_s;
    longint    pose_x, pose_y, pose_z, pose_scale;
    longint    ang_x, ang_y, ang_z;
    column_t   expected_cols[$];
    int        error_count;
    int        cycle_count;
    logic      no_idle;
    step_row_t directed[$];

    euler_trs_model_matrix dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic longint floor_div(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint apply_gain(input logic [31:0] d, input longint g);
        longint sd;
        sd = longint'(signed'(d));
        return floor_div(sd * g, 8);
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return floor_div(a * b + 64'sd32768, 16);
    endfunction

    function automatic longint table_sine(input longint angle);
        longint a, quad, x, x2, t, y, r;
        a = angle & 64'hFFFF;
        quad = a >> 14;
        x = (a & 64'h3FFF) << 16;
        if (quad[0])
        begin
            x = (64'sd1 << 30) - x;
        end
        x2 = (x * x) >>> 30;
        t = 64'sd688904866 - ((x2 * 64'sd76016977) >>> 30);
        t = 64'sd1686629713 - ((x2 * t) >>> 30);
        y = (x * t) >>> 30;
        r = (y + (64'sd1 << 13)) >>> 14;
        return quad[1] ? -r : r;
    endfunction

    // Update the pose for one request and queue its four matrix columns.
    task automatic predict_matrix(input logic [1:0] op, input logic [31:0] dx,
                                  input logic [31:0] dy, input logic [31:0] dz,
                                  input logic [31:0] df);
        longint  sx, cx, sy, cy, sz, cz;
        longint  r[3][3];
        column_t c;
        if (op == OP_TRANSLATE)
        begin
            pose_x = clamp32(pose_x + apply_gain(dx, gain_t));
            pose_y = clamp32(pose_y + apply_gain(dy, gain_t));
            pose_z = clamp32(pose_z + apply_gain(dz, gain_t));
        end
        else if (op == OP_ROTATE)
        begin
            ang_x = (ang_x + apply_gain(dx, gain_r)) & 64'hFFFF;
            ang_y = (ang_y + apply_gain(dy, gain_r)) & 64'hFFFF;
            ang_z = (ang_z + apply_gain(dz, gain_r)) & 64'hFFFF;
        end
        else if (op == OP_SCALE)
        begin
            pose_scale = clamp32(pose_scale + apply_gain(df, gain_s));
        end
        sx = table_sine(ang_x); cx = table_sine(ang_x + 16384);
        sy = table_sine(ang_y); cy = table_sine(ang_y + 16384);
        sz = table_sine(ang_z); cz = table_sine(ang_z + 16384);
        r[0][0] = fx_mul(cz, cy);
        r[1][0] = -fx_mul(sz, cy);
        r[2][0] = sy;
        r[0][1] = fx_mul(sz, cx) + fx_mul(fx_mul(cz, sy), sx);
        r[1][1] = fx_mul(cz, cx) - fx_mul(fx_mul(sz, sy), sx);
        r[2][1] = -fx_mul(cy, sx);
        r[0][2] = fx_mul(sz, sx) - fx_mul(fx_mul(cz, sy), cx);
        r[1][2] = fx_mul(cz, sx) + fx_mul(fx_mul(sz, sy), cx);
        r[2][2] = fx_mul(cy, cx);
        for (int k = 0; k < 3; k++)
        begin
            c.col  = 2'(k);
            c.last = 1'b0;
            c.data = {32'd0,
                      32'(clamp32(fx_mul(pose_scale, r[2][k]))),
                      32'(clamp32(fx_mul(pose_scale, r[1][k]))),
                      32'(clamp32(fx_mul(pose_scale, r[0][k])))};
            expected_cols.push_back(c);
        end
        c.col  = 2'd3;
        c.last = 1'b1;
        c.data = {32'h0001_0000, 32'(pose_z), 32'(pose_y), 32'(pose_x)};
        expected_cols.push_back(c);
    endtask

    // Send one request and record its expected columns.
    task automatic send_request(input logic [1:0] op, input logic [31:0] dx,
                                input logic [31:0] dy, input logic [31:0] dz,
                                input logic [31:0] df);
        while (!no_idle && $urandom_range(99) < 8)
        begin
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {df, dz, dy, dx};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predict_matrix(op, dx, dy, dz, df);
        s_tvalid <= 1'b0;
        // The block stays busy after taking a request, so this edge costs nothing.
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_cols.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_gain(input logic [1:0] idx, input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == CFG_TRANSLATE_GAIN)
        begin
            gain_t = value;
        end
        else if (idx == CFG_ROTATE_GAIN)
        begin
            gain_r = value;
        end
        else if (idx == CFG_SCALE_GAIN)
        begin
            gain_s = value;
        end
    endtask

    function automatic logic [31:0] rand_delta();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(262144)) - 131072);
        endcase
    endfunction

    function automatic step_row_t mk(input logic [1:0] op, input logic [31:0] dx,
                                     input logic [31:0] dy, input logic [31:0] dz,
                                     input logic [31:0] df, input logic chk,
                                     input logic [31:0] fx);
        step_row_t s;
        s.op = op; s.dx = dx; s.dy = dy; s.dz = dz; s.df = df;
        s.check_fixed = chk; s.fixed_row0 = fx;
        return s;
    endfunction

    // Result side: random stalls and column checks.
    always @(posedge clk)
    begin
        column_t exp_c;
        if (rst_n)
        begin
            m_tready <= no_idle || ($urandom_range(99) >= 8);
            if (m_tvalid && m_tready)
            begin
                if (expected_cols.size() == 0)
                begin
                    $display("%0t: unexpected column %0d data %h", $time, m_tuser, m_tdata);
                    error_count++;
                end
                else
                begin
                    exp_c = expected_cols.pop_front();
                    if (m_tuser !== exp_c.col || m_tlast !== exp_c.last)
                    begin
                        $display("%0t: column index/last expected %0d/%0b actual %0d/%0b",
                                 $time, exp_c.col, exp_c.last, m_tuser, m_tlast);
                        error_count++;
                    end
                    for (int j = 0; j < 4; j++)
                    begin
                        if (m_tdata[32*j +: 32] !== exp_c.data[32*j +: 32])
                        begin
                            $display("%0t: column %0d row %0d expected %h actual %h",
                                     $time, exp_c.col, j, exp_c.data[32*j +: 32],
                                     m_tdata[32*j +: 32]);
                            error_count++;
                        end
                    end
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        step_row_t row;
        logic [1:0] op;
        int n;
        rst_n = 1'b0; cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = OP_READ; m_tready = 1'b0;
        error_count = 0; cycle_count = 0; no_idle = 1'b0;
        gain_t = 256; gain_r = 256; gain_s = 256;
        pose_x = 0; pose_y = 0; pose_z = -65536; pose_scale = 131072;
        ang_x = 0; ang_y = 0; ang_z = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; the first row after reset gives a scale of 2 on x.
        directed.push_back(mk(OP_READ, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h5,
                              1'b1, 32'h0002_0000));
        directed.push_back(mk(OP_TRANSLATE, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h7FFF_FFFF,
                              1'b0, 0));
        directed.push_back(mk(OP_TRANSLATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                              1'b0, 0));
        directed.push_back(mk(OP_TRANSLATE, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                              1'b0, 0));
        directed.push_back(mk(OP_ROTATE, 32'h4000, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b0, 0));
        directed.push_back(mk(OP_ROTATE, 32'h0, 32'h2000, 32'hFFFF_C000, 0, 1'b0, 0));
        directed.push_back(mk(OP_ROTATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0,
                              1'b0, 0));
        directed.push_back(mk(OP_ROTATE, 32'h8000, 32'h1234, 32'h10000, 0, 1'b0, 0));
        directed.push_back(mk(OP_SCALE, 32'hFFFF_FFFF, 32'h1, 32'h2, 32'hFFFE_0000, 1'b0, 0));
        directed.push_back(mk(OP_SCALE, 0, 0, 0, 32'h8000_0000, 1'b0, 0));
        directed.push_back(mk(OP_SCALE, 0, 0, 0, 32'h7FFF_FFFF, 1'b0, 0));
        directed.push_back(mk(OP_SCALE, 0, 0, 0, 32'h7FFF_FFFF, 1'b0, 0));
        directed.push_back(mk(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 1'b0, 0));
        directed.push_back(mk(OP_SCALE, 0, 0, 0, 32'h8001_0000, 1'b0, 0));
        foreach (directed[i])
        begin
            row = directed[i];
            send_request(row.op, row.dx, row.dy, row.dz, row.df);
            if (row.check_fixed && expected_cols[expected_cols.size()-4].data[31:0]
                != row.fixed_row0)
            begin
                $display("%0t: table row %0d expected %h model %h", $time, i,
                         row.fixed_row0, expected_cols[expected_cols.size()-4].data[31:0]);
                error_count++;
            end
        end
        wait_drained();

        // Random phases across gain settings, extremes included.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin write_gain(CFG_TRANSLATE_GAIN, 16'h0000);
                         write_gain(CFG_ROTATE_GAIN, 16'hFFFF);
                         write_gain(CFG_SCALE_GAIN, 16'h0000); end
                1: begin write_gain(CFG_TRANSLATE_GAIN, 16'hFFFF);
                         write_gain(CFG_ROTATE_GAIN, 16'h0000);
                         write_gain(CFG_SCALE_GAIN, 16'hFFFF); end
                2: begin write_gain(CFG_TRANSLATE_GAIN, GAIN_RESET);
                         write_gain(CFG_ROTATE_GAIN, GAIN_RESET);
                         write_gain(CFG_SCALE_GAIN, 16'd16);
                         write_gain(CFG_UNUSED_INDEX, 16'hABCD); end
                default: begin
                    write_gain(CFG_TRANSLATE_GAIN, 16'($urandom));
                    write_gain(CFG_ROTATE_GAIN, 16'($urandom));
                    write_gain(CFG_SCALE_GAIN, 16'($urandom_range(512)));
                end
            endcase
            no_idle = (phase == 3);
            n = 75;
            for (int i = 0; i < n; i++)
            begin
                op = 2'($urandom_range(3));
                send_request(op, rand_delta(), rand_delta(), rand_delta(), rand_delta());
                // Let the output side empty out once mid-run.
                if (phase == 4 && i == 30)
                begin
                    while (expected_cols.size() != 0)
                    begin
                        @(posedge clk);
                    end
                end
            end
            no_idle = 1'b0;
            wait_drained();
        end

        repeat (150) @(posedge clk);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
